>>> rtl/feedback_delay_echo_core_defines.svh
// ----------------------------------------------------------------------------
// Feedback delay echo: assertion macros
// Concurrent assertion shorthands sampled on clk_i, disabled while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_ECHO_CORE_DEFINES_SVH
`define FEEDBACK_DELAY_ECHO_CORE_DEFINES_SVH

// same-cycle implication
`define FDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fdecho_pkg.sv
// ----------------------------------------------------------------------------
// Feedback delay echo: package
// Shared widths, constants, sample type and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fdecho_pkg;

  localparam int unsigned MaxDelay    = 65536;
  localparam int unsigned MaxChannels = 2;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned GainW     = 15;
  localparam int unsigned WetW      = 16;
  localparam int unsigned ChanCntW  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SatInW    = 20;

  localparam int unsigned FbCap      = 32113;
  localparam int unsigned WetOne     = 32768;
  localparam int unsigned DelayReset = 24000;
  localparam int unsigned ChanReset  = 2;

  typedef logic signed [SampleW-1:0] sample_t;

  function automatic sample_t sat_s16(input logic signed [SatInW-1:0] v);
    sample_t r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fdecho_ram.sv
// ----------------------------------------------------------------------------
// Feedback delay echo: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdecho_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/fdecho_arith.sv
// ----------------------------------------------------------------------------
// Feedback delay echo: arithmetic
// Registered gain products, then rounding and saturation of the feedback
// write value and the dry/wet mix, or the dry input for an inactive channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fdecho_arith (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  fdecho_pkg::sample_t                 x_i,
  input  fdecho_pkg::sample_t                 dl_i,
  input  logic [fdecho_pkg::GainW-1:0]        gain_i,
  input  logic [fdecho_pkg::WetW-1:0]         wet_i,
  input  logic                                act_i,
  output fdecho_pkg::sample_t                 store_o,
  output fdecho_pkg::sample_t                 result_o
);

  localparam int unsigned GainW = fdecho_pkg::GainW;
  localparam int unsigned WetW  = fdecho_pkg::WetW;

  logic [GainW-1:0]    gain;
  logic [WetW-1:0]     wet;
  logic [WetW-1:0]     dry;
  logic signed [31:0]  p_fb_d, p_fb_q;
  logic signed [32:0]  p_x_d, p_x_q;
  logic signed [32:0]  p_d_d, p_d_q;
  fdecho_pkg::sample_t x_q;

  logic signed [31:0]  fb_sum;
  logic signed [16:0]  fb;
  logic signed [17:0]  st_sum;
  logic signed [33:0]  mix_sum;
  logic signed [18:0]  mix;
  fdecho_pkg::sample_t mix_sat;

  always_comb begin
    gain   = (gain_i > GainW'(fdecho_pkg::FbCap)) ? GainW'(fdecho_pkg::FbCap) : gain_i;
    wet    = (wet_i > WetW'(fdecho_pkg::WetOne)) ? WetW'(fdecho_pkg::WetOne) : wet_i;
    dry    = WetW'(fdecho_pkg::WetOne) - wet;
    p_fb_d = dl_i * $signed({1'b0, gain});
    p_x_d  = x_i * $signed({1'b0, dry});
    p_d_d  = dl_i * $signed({1'b0, wet});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_fb_q <= p_fb_d;
      p_x_q  <= p_x_d;
      p_d_q  <= p_d_d;
      x_q    <= x_i;
    end
  end

  // floor((v + 2^14) / 2^15) by taking the upper bits
  always_comb begin
    fb_sum  = p_fb_q + 32'sd16384;
    fb      = fb_sum[31:15];
    st_sum  = {{2{x_q[15]}}, x_q} + {fb[16], fb};
    mix_sum = {p_x_q[32], p_x_q} + {p_d_q[32], p_d_q} + 34'sd16384;
    mix     = mix_sum[33:15];
    mix_sat = fdecho_pkg::sat_s16({mix[18], mix});
  end

  assign store_o  = fdecho_pkg::sat_s16({{2{st_sum[17]}}, st_sum});
  assign result_o = act_i ? mix_sat : x_q;

endmodule

`default_nettype wire

>>> rtl/feedback_delay_echo_core.sv
// ----------------------------------------------------------------------------
// Feedback delay echo core
// Multichannel echo: per-channel circular delay store in one RAM, feedback
// written back saturated, dry/wet mix out.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata sample_in, tuser channel
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata sample_out
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle while m_axis is ready and no read waits on a pending write.
// An item that reads the entry the item just ahead of it writes (delay of one
// frame with one active channel) waits in the read stage until that write is done.
// After reset the store is cleared one entry per cycle, all MaxChannels*MaxDelay
// entries (131072 by default), with s_axis_tready low; cfg is always ready.
// Backpressure on m_axis stalls the pipe stage by stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "feedback_delay_echo_core_defines.svh"

module feedback_delay_echo_core #(
  parameter int unsigned MaxDelay    = fdecho_pkg::MaxDelay,
  parameter int unsigned MaxChannels = fdecho_pkg::MaxChannels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fdecho_pkg::SampleW-1:0]       s_axis_tdata,   // [15:0] sample_in
  input  logic [0:0]                           s_axis_tuser,   // [0] channel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fdecho_pkg::SampleW-1:0]       m_axis_tdata,   // [15:0] sample_out
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fdecho_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fdecho_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned Depth    = MaxChannels * MaxDelay;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned PW       = $clog2(MaxDelay);
  localparam int unsigned DelayW   = fdecho_pkg::DelayW;
  localparam int unsigned GainW    = fdecho_pkg::GainW;
  localparam int unsigned WetW     = fdecho_pkg::WetW;
  localparam int unsigned ChanCntW = fdecho_pkg::ChanCntW;
  localparam int unsigned SW       = ((PW > DelayW) ? PW : DelayW) + 2;
  localparam int unsigned NW       = ($clog2(MaxChannels + 1) > ChanCntW) ?
                                     $clog2(MaxChannels + 1) : ChanCntW;

  typedef enum logic [fdecho_pkg::CfgIdxW-1:0] {
    REG_DELAY_LENGTH    = 2'd0,
    REG_FEEDBACK_GAIN   = 2'd1,
    REG_WET_LEVEL       = 2'd2,
    REG_ACTIVE_CHANNELS = 2'd3
  } cfg_reg_e;

  // config registers
  logic [DelayW-1:0]   delay_length_q;
  logic [GainW-1:0]    feedback_gain_q;
  logic [WetW-1:0]     wet_level_q;
  logic [ChanCntW-1:0] active_channels_q;

  // store clearing
  logic          clearing_q;
  logic [AW-1:0] clr_q;

  logic [PW-1:0] wp_q, wp_d;

  // read stage
  logic                s1_v_q, s1_act_q, fwd_q;
  fdecho_pkg::sample_t s1_x_q, fwd_data_q;
  logic [AW-1:0]       s1_ra_q, s1_wa_q;

  // arithmetic stage
  logic          s2_v_q, s2_act_q;
  logic [AW-1:0] s2_wa_q;

  // output register
  logic                out_v_q;
  fdecho_pkg::sample_t out_data_q;

  logic                in_ch;
  logic [NW-1:0]       nch;
  logic                in_act, in_last;
  logic [SW-1:0]       d_len, t_pos, rp_wide;
  logic [PW-1:0]       rp;
  logic [AW-1:0]       base, ra, wa, track_ra;
  logic                s_acc, out_en, s2_go, s2_free, s1_hazard, s1_go, s1_free, wr_en;
  fdecho_pkg::sample_t ram_rdata, s1_dl, store_val, result_val;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_ch = s_axis_tuser[0];
    nch   = (active_channels_q == '0) ? NW'(1) : NW'(active_channels_q);
    if (nch > NW'(MaxChannels)) begin
      nch = NW'(MaxChannels);
    end
    in_act  = NW'(in_ch) < nch;
    in_last = NW'(in_ch) == (nch - NW'(1));

    d_len = (delay_length_q == '0) ? SW'(1) : SW'(delay_length_q);
    if (d_len > SW'(MaxDelay)) begin
      d_len = SW'(MaxDelay);
    end
    t_pos   = SW'(wp_q) + SW'(MaxDelay) - d_len;
    rp_wide = (t_pos >= SW'(MaxDelay)) ? t_pos - SW'(MaxDelay) : t_pos;
    rp      = rp_wide[PW-1:0];
    base    = in_ch ? AW'(MaxDelay) : '0;
    ra      = AW'(rp) + base;
    wa      = AW'(wp_q) + base;
    wp_d    = (wp_q == PW'(MaxDelay - 1)) ? '0 : wp_q + PW'(1);
  end

  // stage handshakes
  always_comb begin
    out_en    = !out_v_q || m_axis_tready;
    s2_go     = s2_v_q && out_en;
    s2_free   = !s2_v_q || s2_go;
    s1_hazard = s1_v_q && s1_act_q && s2_v_q && s2_act_q && (s2_wa_q == s1_ra_q);
    s1_go     = s1_v_q && s2_free && !s1_hazard;
    s1_free   = !s1_v_q || s1_go;
    s_axis_tready = s1_free && !clearing_q;
    s_acc     = s_axis_tvalid && s_axis_tready;
    wr_en     = s2_go && s2_act_q;
    track_ra  = s_acc ? ra : s1_ra_q;
    s1_dl     = fwd_q ? fwd_data_q : ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q    <= DelayW'(fdecho_pkg::DelayReset);
      feedback_gain_q   <= '0;
      wet_level_q       <= '0;
      active_channels_q <= ChanCntW'(fdecho_pkg::ChanReset);
      clearing_q        <= 1'b1;
      clr_q             <= '0;
      wp_q              <= '0;
      s1_v_q            <= 1'b0;
      s1_act_q          <= 1'b0;
      fwd_q             <= 1'b0;
      s2_v_q            <= 1'b0;
      s2_act_q          <= 1'b0;
      out_v_q           <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DELAY_LENGTH:    delay_length_q    <= cfg_data_i[DelayW-1:0];
          REG_FEEDBACK_GAIN:   feedback_gain_q   <= cfg_data_i[GainW-1:0];
          REG_WET_LEVEL:       wet_level_q       <= cfg_data_i[WetW-1:0];
          REG_ACTIVE_CHANNELS: active_channels_q <= cfg_data_i[ChanCntW-1:0];
          default: ;
        endcase
      end

      if (clearing_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          clearing_q <= 1'b0;
        end
      end

      if (s_acc && in_act && in_last) begin
        wp_q <= wp_d;
      end

      if (s_acc) begin
        s1_v_q   <= 1'b1;
        s1_act_q <= in_act;
      end else if (s1_go) begin
        s1_v_q   <= 1'b0;
      end

      // newest write to the entry the read stage holds wins
      if (wr_en && (s2_wa_q == track_ra)) begin
        fwd_q <= 1'b1;
      end else if (s_acc) begin
        fwd_q <= 1'b0;
      end

      if (s1_go) begin
        s2_v_q   <= 1'b1;
        s2_act_q <= s1_act_q;
      end else if (s2_go) begin
        s2_v_q   <= 1'b0;
      end

      if (s2_go) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_x_q  <= s_axis_tdata;
      s1_ra_q <= ra;
      s1_wa_q <= wa;
    end
    if (wr_en && (s2_wa_q == track_ra)) begin
      fwd_data_q <= store_val;
    end
    if (s1_go) begin
      s2_wa_q <= s1_wa_q;
    end
    if (s2_go) begin
      out_data_q <= result_val;
    end
  end

  fdecho_ram #(
    .Width (fdecho_pkg::SampleW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (clearing_q || wr_en),
    .waddr_i (clearing_q ? clr_q : s2_wa_q),
    .wdata_i (clearing_q ? '0 : store_val),
    .re_i    (s_acc && in_act),
    .raddr_i (ra),
    .rdata_o (ram_rdata)
  );

  fdecho_arith u_arith (
    .clk_i    (clk_i),
    .en_i     (s1_go),
    .x_i      (s1_x_q),
    .dl_i     (s1_dl),
    .gain_i   (feedback_gain_q),
    .wet_i    (wet_level_q),
    .act_i    (s2_act_q),
    .store_o  (store_val),
    .result_o (result_val)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  `FDE_ASSERT_IMP(a_no_accept_while_clearing, clearing_q, !s_axis_tready, "item accepted during store clear")
  `FDE_ASSERT_IMP(a_hold_on_hazard, s1_hazard, !s1_go, "read stage advanced past pending write")
  `FDE_ASSERT_IMP(a_wp_in_range, 1'b1, int'(wp_q) < MaxDelay, "write position out of range")
  `FDE_ASSERT_NXT(a_fwd_capture, wr_en && s1_v_q && !s1_go && !s_acc && (s2_wa_q == s1_ra_q), fwd_q, "write to held read entry not forwarded")
  `FDE_ASSERT_IMP(a_no_write_while_clearing, clearing_q, !s2_v_q && !s1_v_q, "pipeline busy during store clear")

endmodule

`default_nettype wire

>>> tb/feedback_delay_echo_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay echo core: self-checking testbench
// Streams interleaved samples through the echo core and checks every output
// sample against an in-bench model of the per-channel delay store, feedback
// write-back and dry/wet mix. Runs directed corner settings, then randomized
// register settings with random source and sink idling, one long sink stall.
// ----------------------------------------------------------------------------

module feedback_delay_echo_core_test;
  import fdecho_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    RegDelay    = 2'd0,
    RegFeedback = 2'd1,
    RegWet      = 2'd2,
    RegChannels = 2'd3
  } echo_reg_e;

  typedef struct packed {
    logic    ch;
    sample_t smp;
  } frame_item_t;

  localparam int RandPhases    = 10;
  localparam int PhaseItems    = 100;
  localparam int LongHoldCyc   = 300;
  localparam int LongHoldAfter = 200;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SampleW-1:0]  m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = RegDelay;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  feedback_delay_echo_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [DelayW-1:0]   cur_delay = DelayW'(DelayReset);
  logic [GainW-1:0]    cur_gain  = '0;
  logic [WetW-1:0]     cur_wet   = '0;
  logic [ChanCntW-1:0] cur_chans = ChanCntW'(ChanReset);
  logic [15:0]         wr_pos    = '0;
  sample_t             echo_store [MaxChannels][MaxDelay];

  frame_item_t pending_samples[$];
  sample_t     echo_expect[$];
  bit          idling_on  = 1'b1;
  int          mismatches = 0;

  function automatic int unsigned active_count();
    if (cur_chans == 0) return 1;
    if (cur_chans > MaxChannels) return MaxChannels;
    return cur_chans;
  endfunction

  function automatic sample_t clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v[15:0]);
  endfunction

  function automatic sample_t echo_predict(input logic ch, input sample_t x);
    int unsigned nch, g, w;
    logic [15:0] d, rd_pos;
    longint      dl, fb, mix;
    sample_t     y;
    nch = active_count();
    if (ch >= nch) return x;
    d      = (cur_delay == 0) ? 16'd1 : cur_delay;
    rd_pos = wr_pos - d;
    dl     = echo_store[ch][rd_pos];
    g      = (cur_gain > FbCap) ? FbCap : cur_gain;
    w      = (cur_wet > WetOne) ? WetOne : cur_wet;
    fb     = (dl * longint'(g) + 16384) >>> 15;
    echo_store[ch][wr_pos] = clip16(longint'(x) + fb);
    mix    = longint'(x) * longint'(WetOne - w) + dl * longint'(w) + 16384;
    y      = clip16(mix >>> 15);
    if (ch == nch - 1) wr_pos = wr_pos + 16'd1;
    return y;
  endfunction

  // source side
  frame_item_t on_bus;
  int          send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        echo_expect.push_back(echo_predict(on_bus.ch, on_bus.smp));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          on_bus = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.smp;
          s_axis_tuser  <= on_bus.ch;
          if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: check, random stalls, one long hold
  int      out_count  = 0;
  int      stall_left = 0;
  int      hold_left  = 0;
  bit      hold_done  = 1'b0;
  sample_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_count++;
        if (echo_expect.size() == 0) begin
          $error("sample_out: unexpected item, got %0d", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = echo_expect.pop_front();
          if (m_axis_tdata !== want) begin
            $error("sample_out: expected %0d, got %0d", want, $signed(m_axis_tdata));
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && out_count >= LongHoldAfter) begin
        hold_done = 1'b1;
        hold_left = LongHoldCyc - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input echo_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegDelay:    cur_delay = val;
      RegFeedback: cur_gain  = val[GainW-1:0];
      RegWet:      cur_wet   = val;
      RegChannels: cur_chans = val[ChanCntW-1:0];
      default: ;
    endcase
  endtask

  task automatic offer(input logic ch, input sample_t smp);
    pending_samples.push_back('{ch: ch, smp: smp});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || echo_expect.size() != 0);
  endtask

  initial begin
    logic [15:0] dly, gain, wet;
    int unsigned nch;
    logic        ch;
    sample_t     smp;

    foreach (echo_store[c, a]) echo_store[c][a] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero delay, feedback and wet above their caps, two channels
    write_reg(RegDelay, 16'd0);
    write_reg(RegFeedback, 16'hFFFF);
    write_reg(RegWet, 16'hFFFF);
    write_reg(RegChannels, 16'd2);
    offer(1'b0, 16'sh7FFF);
    offer(1'b1, 16'sh8000);
    offer(1'b0, 16'sh7FFF);
    offer(1'b1, 16'sh8000);
    offer(1'b0, 16'sh8000);
    offer(1'b1, 16'sh7FFF);
    offer(1'b0, 16'sh0000);
    offer(1'b1, 16'shFFFF);
    wait_drained();

    // one channel, one-frame delay: back-to-back read of the entry just written
    write_reg(RegDelay, 16'd1);
    write_reg(RegFeedback, 16'(FbCap));
    write_reg(RegWet, 16'd16384);
    write_reg(RegChannels, 16'd1);
    offer(1'b0, 16'sh7FFF);
    offer(1'b0, 16'sh7FFF);
    offer(1'b0, 16'sh7FFF);
    offer(1'b1, 16'sh04D2);
    offer(1'b0, 16'sh8000);
    offer(1'b0, 16'sh8000);
    offer(1'b0, 16'sh0000);
    wait_drained();

    // longest delay; channel count of zero, then above the maximum
    write_reg(RegDelay, 16'hFFFF);
    write_reg(RegFeedback, 16'd0);
    write_reg(RegWet, 16'd0);
    write_reg(RegChannels, 16'd0);
    offer(1'b0, 16'sh0064);
    offer(1'b1, -16'sh0064);
    wait_drained();
    write_reg(RegChannels, 16'd3);
    offer(1'b1, -16'sh0007);
    offer(1'b0, 16'sh0007);
    offer(1'b1, 16'sh7FFF);
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      idling_on = (ph != RandPhases - 1);
      case ($urandom_range(0, 9))
        0:       dly = 16'd0;
        1:       dly = 16'hFFFF;
        2:       dly = 16'($urandom);
        default: dly = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0:       gain = 16'h7FFF;
        1:       gain = 16'($urandom);
        default: gain = 16'($urandom_range(0, FbCap));
      endcase
      case ($urandom_range(0, 4))
        0:       wet = 16'(WetOne);
        1:       wet = 16'($urandom);
        2:       wet = 16'd0;
        default: wet = 16'($urandom_range(0, WetOne));
      endcase
      write_reg(RegDelay, dly);
      write_reg(RegFeedback, gain);
      write_reg(RegWet, wet);
      write_reg(RegChannels, (ph % 4 == 0) ? 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(1, 2)));
      nch = active_count();
      for (int n = 0; n < PhaseItems; n++) begin
        ch = (nch == 2) ? n[0] : 1'b0;
        if ($urandom_range(0, 9) == 0) ch = 1'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       smp = 16'sh7FFF;
            1:       smp = 16'sh8000;
            2:       smp = 16'sh0000;
            default: smp = 16'shFFFF;
          endcase
        end else begin
          smp = sample_t'($urandom);
        end
        offer(ch, smp);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (echo_expect.size() != 0) begin
      $error("sample_out: %0d expected items never arrived", echo_expect.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("feedback_delay_echo_core verification clean");
    end else begin
      $display("feedback_delay_echo_core verification failed");
    end
    $finish;
  end

  // timeout covering the store clear after reset and the whole run
  initial begin
    #4000000;
    $display("feedback_delay_echo_core verification failed");
    $finish;
  end

endmodule
